>>> rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package deq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned ERR_W = 2;
  localparam int unsigned WORD_W = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REVERSE    = 3'd4,
    CMD_PEEK       = 3'd5
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  // Per-command control handed from the pointer logic to the ring memory.
  typedef struct packed {
    logic wr_en;      // write the pushed word this cycle
    logic rd_en;      // command accepted: launch reads, capture status
    logic fwd_first;  // first-word read hits the entry written this cycle
    logic fwd_last;   // last-word read hits the entry written this cycle
    logic reversed;   // orientation after the command
    err_t err;
  } ring_req_t;

endpackage

`default_nettype wire

>>> rtl/deq_ctrl.sv
// Pointer and command logic: head pointer, word count and orientation flag.
// Depends on deq_pkg; drives the ring memory addresses and control.
`default_nettype none

module deq_ctrl #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [deq_pkg::CMD_W-1:0] cmd,
  output deq_pkg::ring_req_t        req,
  output logic [AW-1:0]             waddr,
  output logic [AW-1:0]             raddr_first,
  output logic [AW-1:0]             raddr_last,
  output logic [CW-1:0]             count_after
);
  import deq_pkg::*;

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic          rev, rev_next;
  logic          wr;
  err_t          err;
  cmd_t          op;
  logic          empty, full, push_last, pop_last;
  logic [AW-1:0] head_dec, head_inc;

  // Ring index at distance k past base, k below DEPTH.
  function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] base,
                                            input logic [AW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, k};
    return (s >= (AW+1)'(DEPTH)) ? AW'(s - (AW+1)'(DEPTH)) : s[AW-1:0];
  endfunction

  assign op        = cmd_t'(cmd);
  assign empty     = (count == '0);
  assign full      = (count == CW'(DEPTH));
  assign push_last = (op == CMD_PUSH_BACK) != rev;
  assign pop_last  = (op == CMD_POP_BACK) != rev;
  assign head_dec  = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc  = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  always_comb begin
    head_next  = head;
    count_next = count;
    rev_next   = rev;
    wr         = 1'b0;
    err        = ERR_NONE;
    waddr      = ring_at(head, AW'(count));
    unique case (op)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          wr         = 1'b1;
          count_next = count + CW'(1);
          if (!push_last) begin
            head_next = head_dec;
            waddr     = head_dec;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty) begin
          err = ERR_EMPTY;
        end else begin
          count_next = count - CW'(1);
          if (!pop_last) begin
            head_next = head_inc;
          end
        end
      end
      CMD_REVERSE: begin
        if (empty) begin
          err = ERR_EMPTY;
        end else begin
          rev_next = !rev;
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          err = ERR_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  assign raddr_first = head_next;
  assign raddr_last  = ring_at(head_next, AW'(count_next - CW'(1)));
  assign count_after = count_next;

  always_comb begin
    req.wr_en     = accept && wr;
    req.rd_en     = accept;
    req.fwd_first = wr && (waddr == raddr_first);
    req.fwd_last  = wr && (waddr == raddr_last);
    req.reversed  = rev_next;
    req.err       = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else if (accept) begin
      head  <= head_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("word count exceeds ring depth");
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= AW'(DEPTH - 1))
    else $error("head pointer outside ring");
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(head) && $stable(count) && $stable(rev))
    else $error("pointer state moved without a command");
  a_fail_hold: assert property (@(posedge clk) disable iff (rst)
    accept && (err != ERR_NONE) |=> $stable(head) && $stable(count) && $stable(rev))
    else $error("failed command changed state");
`endif

endmodule

`default_nettype wire

>>> rtl/deq_ring.sv
// Ring memory with one write port and two registered read ports, plus the
// read-stage forwarding and result assembly. Depends on deq_pkg.
`default_nettype none

module deq_ring #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  deq_pkg::ring_req_t         req,
  input  logic [AW-1:0]              waddr,
  input  logic [deq_pkg::WORD_W-1:0] wdata,
  input  logic [AW-1:0]              raddr_first,
  input  logic [AW-1:0]              raddr_last,
  input  logic [CW-1:0]              count_after,
  output logic [deq_pkg::WORD_W-1:0] front_word,
  output logic [deq_pkg::WORD_W-1:0] back_word,
  output logic [CW-1:0]              count_word,
  output deq_pkg::err_t              err_word
);
  import deq_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_first, rd_last, wdata_q;
  logic              fwd_first_q, fwd_last_q, rev_q;
  logic [CW-1:0]     count_q;
  err_t              err_q;
  logic [WORD_W-1:0] first, last;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Reads see the old entry when written in the same cycle; forward the word.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_first    <= mem[raddr_first];
      rd_last     <= mem[raddr_last];
      wdata_q     <= wdata;
      fwd_first_q <= req.fwd_first;
      fwd_last_q  <= req.fwd_last;
      rev_q       <= req.reversed;
      count_q     <= count_after;
      err_q       <= req.err;
    end
  end

  always_comb begin
    first = fwd_first_q ? wdata_q : rd_first;
    last  = fwd_last_q  ? wdata_q : rd_last;
    if (count_q == '0) begin
      first = '0;
      last  = '0;
    end
  end

  assign front_word = rev_q ? last : first;
  assign back_word  = rev_q ? first : last;
  assign count_word = count_q;
  assign err_word   = err_q;

endmodule

`default_nettype wire

>>> rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: handshakes and output register.
// Depends on deq_pkg, deq_ctrl and deq_ring.
//
// Usage:
//   Input channel (in_valid/in_ready, cmd, value) carries one command per
//   transfer: push back, push front, pop front, pop back, reverse or peek.
//   Output channel (out_valid/out_ready) returns exactly one result per
//   command: front and back words, entry count, empty flag, error code.
//   Words live in a ring memory of DEPTH entries; reverse only flips an
//   orientation bit, so every command touches the ring ends only.
//   At the accepting edge the pointers update, the ring is written and both
//   registered reads launch; the read stage then loads the output register,
//   from which the result transfers. Throughput: one command per cycle
//   unless out_ready stalls; a same-cycle write/read hit forwards.
//   Stall: when out_ready is low the output register holds its result, the
//   read stage holds behind it, and in_ready drops once both are full.
//   Reset (rst, synchronous): count, head and orientation clear, both
//   pipeline valids drop; ring contents stay undefined, no clearing pass.
//   Errors (pop/peek/reverse on empty, push on full) leave state unchanged.
`default_nettype none

module double_ended_queue_unit #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [deq_pkg::CMD_W-1:0]  cmd,
  input  logic [deq_pkg::WORD_W-1:0] value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [deq_pkg::WORD_W-1:0] front_value,
  output logic [deq_pkg::WORD_W-1:0] back_value,
  output logic [CW-1:0]              entry_count,
  output logic                       is_empty,
  output logic [deq_pkg::ERR_W-1:0]  error_code
);
  import deq_pkg::*;

  ring_req_t         req;
  logic [AW-1:0]     waddr, raddr_first, raddr_last;
  logic [CW-1:0]     count_after;
  logic [WORD_W-1:0] front_word, back_word;
  logic [CW-1:0]     count_word;
  err_t              err_word;
  logic              accept;
  logic              rd_valid;   // read stage holds a result
  logic              rd_move;    // read stage advances to the output register

  // Advance the read stage whenever the output register is free or draining.
  assign rd_move  = rd_valid && (!out_valid || out_ready);
  assign in_ready = !rd_valid || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  deq_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .req         (req),
    .waddr       (waddr),
    .raddr_first (raddr_first),
    .raddr_last  (raddr_last),
    .count_after (count_after)
  );

  deq_ring #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ring (
    .clk         (clk),
    .req         (req),
    .waddr       (waddr),
    .wdata       (value),
    .raddr_first (raddr_first),
    .raddr_last  (raddr_last),
    .count_after (count_after),
    .front_word  (front_word),
    .back_word   (back_word),
    .count_word  (count_word),
    .err_word    (err_word)
  );

  // Pipeline valids: a new transfer refills the read stage as it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        rd_valid <= 1'b1;
      end else if (rd_move) begin
        rd_valid <= 1'b0;
      end
      if (rd_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload: load on advance, hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rd_move) begin
      front_value <= front_word;
      back_value  <= back_word;
      entry_count <= count_word;
      is_empty    <= (count_word == '0);
      error_code  <= err_word;
    end
  end

`ifndef SYNTHESIS
  a_out_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= CW'(DEPTH))
    else $error("reported count exceeds ring depth");
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (front_value == '0) && (back_value == '0))
    else $error("empty deque reports nonzero words");
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (entry_count == CW'(1)) |-> (front_value == back_value))
    else $error("single word differs between front and back");
  a_full_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code == ERR_FULL) |-> (entry_count == CW'(DEPTH)))
    else $error("full error reported below depth");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    rd_valid && out_valid && !out_ready |-> !accept)
    else $error("command accepted over a held read stage");
`endif

endmodule

`default_nettype wire

>>> dv/double_ended_queue_unit_test.sv
// Self-checking testbench for double_ended_queue_unit: directed table, then biased random commands.
// Depends on rtl/deq_pkg.sv and the double_ended_queue_unit RTL; reads no files.
// Results are checked against a cycle-free deque predictor in this module or a hand-typed result.

module double_ended_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEFAULT;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 225;
  localparam int unsigned SCRIPT_LEN = 23;

  // Command codes the block must ignore.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

  typedef struct packed {
    logic [WORD_W-1:0] front;
    logic [WORD_W-1:0] back;
    logic [CNT_W-1:0]  count;
    logic              empty;
    err_t              err;
  } deq_status_t;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [WORD_W-1:0] word;
    logic [4:0]        reps;   // issue the row this many times, word + k
    logic              typed;  // want holds the result typed in by hand
    deq_status_t       want;
  } script_row_t;

  // Directed walk: empty errors, extremes, orientation flip, fill to full, drain.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{CMD_POP_FRONT,  '0, 5'd1, 1'b1, '{'0, '0, 5'd0, 1'b1, ERR_EMPTY}},
    '{CMD_POP_BACK,   '0, 5'd1, 1'b1, '{'0, '0, 5'd0, 1'b1, ERR_EMPTY}},
    '{CMD_REVERSE,    '0, 5'd1, 1'b1, '{'0, '0, 5'd0, 1'b1, ERR_EMPTY}},
    '{CMD_PEEK,       '0, 5'd1, 1'b1, '{'0, '0, 5'd0, 1'b1, ERR_EMPTY}},
    '{CMD_SPARE_LO, ONES, 5'd1, 1'b1, '{'0, '0, 5'd0, 1'b1, ERR_NONE}},
    '{CMD_PUSH_BACK, ONES, 5'd1, 1'b1, '{ONES, ONES, 5'd1, 1'b0, ERR_NONE}},
    '{CMD_PUSH_FRONT,  '0, 5'd1, 1'b1, '{'0, ONES, 5'd2, 1'b0, ERR_NONE}},
    '{CMD_REVERSE,     '0, 5'd1, 1'b1, '{ONES, '0, 5'd2, 1'b0, ERR_NONE}},
    '{CMD_PUSH_BACK,  64'h8000_0000_0000_0001, 5'd1, 1'b0, '0},
    '{CMD_PUSH_FRONT, 64'h5555_5555_5555_5555, 5'd1, 1'b0, '0},
    '{CMD_PEEK,       '0, 5'd1, 1'b0, '0},
    '{CMD_POP_FRONT,  '0, 5'd1, 1'b0, '0},
    '{CMD_POP_BACK,   '0, 5'd1, 1'b0, '0},
    '{CMD_SPARE_HI,   '0, 5'd1, 1'b0, '0},
    '{CMD_PUSH_BACK,  64'h0123_4567_89AB_CDEF, 5'd14, 1'b0, '0},
    '{CMD_PUSH_FRONT, ONES, 5'd1, 1'b0, '0},
    '{CMD_PUSH_BACK,  '0, 5'd1, 1'b0, '0},
    '{CMD_REVERSE,    '0, 5'd1, 1'b0, '0},
    '{CMD_PEEK,       '0, 5'd1, 1'b0, '0},
    '{CMD_POP_BACK,   '0, 5'd16, 1'b0, '0},
    '{CMD_POP_BACK,   '0, 5'd1, 1'b1, '{'0, '0, 5'd0, 1'b1, ERR_EMPTY}},
    '{CMD_PUSH_FRONT, 64'hAAAA_AAAA_AAAA_AAAA, 5'd1, 1'b1,
      '{64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 5'd1, 1'b0, ERR_NONE}},
    '{CMD_POP_FRONT,  '0, 5'd1, 1'b1, '{'0, '0, 5'd0, 1'b1, ERR_NONE}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = '0;
  logic [WORD_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WORD_W-1:0] front_value;
  logic [WORD_W-1:0] back_value;
  logic [CNT_W-1:0] entry_count;
  logic is_empty;
  logic [ERR_W-1:0] error_code;

  // Predictor state: a private copy of the ring, its pointers and orientation.
  logic [WORD_W-1:0] ring_copy [DEPTH];
  int unsigned head_idx = 0;
  int unsigned fill = 0;
  logic flipped = 1'b0;

  deq_status_t status_due [$];
  deq_status_t oldest_due;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Shared knobs between the sender and the receiver.
  bit quiet = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  double_ended_queue_unit #(.DEPTH(DEPTH)) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .front_value (front_value),
    .back_value  (back_value),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .error_code  (error_code)
  );

  always #6 clk = ~clk;

  // Apply one command to the predictor and return the status it leaves behind.
  // A failing command changes nothing; spare codes report the current state.
  function automatic deq_status_t apply_command(input logic [CMD_W-1:0] op,
                                                input logic [WORD_W-1:0] word);
    deq_status_t result;
    logic at_last;
    logic [WORD_W-1:0] first_w;
    logic [WORD_W-1:0] last_w;
    result.err = ERR_NONE;
    case (op)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (fill == DEPTH) begin
          result.err = ERR_FULL;
        end else begin
          // Back is the physical end unless the orientation is flipped.
          at_last = (op == CMD_PUSH_BACK) != flipped;
          if (at_last) begin
            ring_copy[IDX_W'((head_idx + fill) % DEPTH)] = word;
          end else begin
            head_idx = (head_idx + DEPTH - 1) % DEPTH;
            ring_copy[IDX_W'(head_idx)] = word;
          end
          fill++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill == 0) begin
          result.err = ERR_EMPTY;
        end else begin
          at_last = (op == CMD_POP_BACK) != flipped;
          if (!at_last) head_idx = (head_idx + 1) % DEPTH;
          fill--;
        end
      end
      CMD_REVERSE: begin
        if (fill == 0) result.err = ERR_EMPTY;
        else flipped = ~flipped;
      end
      CMD_PEEK: begin
        if (fill == 0) result.err = ERR_EMPTY;
      end
      default: ;
    endcase
    first_w = '0;
    last_w = '0;
    if (fill != 0) begin
      first_w = ring_copy[IDX_W'(head_idx)];
      last_w = ring_copy[IDX_W'((head_idx + fill - 1) % DEPTH)];
    end
    result.front = flipped ? last_w : first_w;
    result.back = flipped ? first_w : last_w;
    result.count = CNT_W'(fill);
    result.empty = (fill == 0);
    return result;
  endfunction

  // Offer one command, hold it until the transfer, then record what it must return.
  task automatic send_command(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] word,
                              input logic typed, input deq_status_t typed_status);
    deq_status_t predicted;
    while (!quiet && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    value <= word;
    do @(posedge clk); while (!in_ready);
    predicted = apply_command(op, word);
    status_due.push_back(typed ? typed_status : predicted);
  endtask

  // Wait until every recorded result has come back.
  task automatic drain_results();
    while (status_due.size() != 0) @(posedge clk);
  endtask

  // Random command, with pushes weighted by push_pct; a little noise mixed in.
  task automatic send_random(input int unsigned push_pct);
    int unsigned roll;
    logic [CMD_W-1:0] op;
    logic [WORD_W-1:0] word;
    roll = $urandom_range(99);
    if (roll < 3) op = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    else if (roll < 7) op = CMD_REVERSE;
    else if (roll < 12) op = CMD_PEEK;
    else if ($urandom_range(99) < push_pct)
      op = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    else
      op = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
    case ($urandom_range(9))
      0: word = '0;
      1: word = ONES;
      default: word = {$urandom, $urandom};
    endcase
    send_command(op, word, 1'b0, '0);
  endtask

  // Receiver: random back-pressure, plus a long hold-off whenever the sender asks.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 14);
    end
  end

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        $display("%0t: result with nothing expected, front %0h back %0h count %0d",
                 $time, front_value, back_value, entry_count);
        mismatch_count++;
      end else begin
        oldest_due = status_due.pop_front();
        check_field("front_value", oldest_due.front, front_value);
        check_field("back_value", oldest_due.back, back_value);
        check_field("entry_count", WORD_W'(oldest_due.count), WORD_W'(entry_count));
        check_field("is_empty", WORD_W'(oldest_due.empty), WORD_W'(is_empty));
        check_field("error_code", WORD_W'(oldest_due.err), WORD_W'(error_code));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, status_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned push_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      for (int k = 0; k < SCRIPT[i].reps; k++)
        send_command(SCRIPT[i].op, SCRIPT[i].word + k, SCRIPT[i].typed, SCRIPT[i].want);
    end

    // Random phases: fill-heavy, drain-heavy, mixed; repeat once more.
    // Phase 3 runs with no idling on either side; mixed phases carry a long hold-off.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: push_pct = 70;
        1: push_pct = 30;
        default: push_pct = 50;
      endcase
      quiet = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase % 3 == 2 && n == 60) holds_asked++;
        send_random(push_pct);
      end
      in_valid <= 1'b0;
      drain_results();
      @(posedge clk);
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_ring.sv
rtl/double_ended_queue_unit.sv
dv/double_ended_queue_unit_test.sv
